@@ design/lfo_waveform_sample_hold_assert.svh @@
// Assertion macros for the LFO waveform and sample-and-hold block.
`ifndef LFO_WAVEFORM_SAMPLE_HOLD_ASSERT_SVH
`define LFO_WAVEFORM_SAMPLE_HOLD_ASSERT_SVH
`ifndef SYNTHESIS
// Whenever the antecedent holds, the consequent holds in the same cycle.
`define LWS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfo_waveform_sample_hold: same-cycle check failed");
// Whenever the antecedent holds, the consequent holds in the next cycle.
`define LWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfo_waveform_sample_hold: next-cycle check failed");
`else
`define LWS_ASSERT_SAME(lbl, ante, cons)
`define LWS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/lws_pkg.sv @@
// Types, codes and the noise step function shared by the LFO waveform block.
package lws_pkg;

  typedef enum logic [1:0] {
    WAVE_SAW    = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_SH     = 2'd3
  } wave_t;

  localparam int unsigned CYCLE_W = 16;
  localparam int unsigned PHASE_W = 8;
  localparam int unsigned AMP_W   = 8;
  localparam int unsigned PITCH_W = 9;
  localparam int unsigned DRAW_BITS = 8;

  localparam logic [AMP_W-1:0] HELD_RESET = 8'd128;

  typedef struct packed {
    logic [15:0] shift;
    logic        prior;
  } noise_t;

  // Request from the pipeline to the sample-and-hold unit.
  typedef struct packed {
    logic               take;
    logic [CYCLE_W-1:0] cycle;
  } hold_req_t;

  // One step of the noise register, with the escape from the all-zero state.
  function automatic noise_t noise_step(noise_t s);
    noise_t n;
    logic   top;
    if (s.shift == 16'd0 && !s.prior) begin
      top = 1'b1;
    end else begin
      top = s.shift[2] ^ s.prior;
    end
    n.prior = s.shift[0];
    n.shift = {top, s.shift[15:1]};
    return n;
  endfunction

endpackage

@@ design/lws_if.sv @@
// Valid/ready channel interfaces for the input phase and the result codes.
interface lws_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] cycle_count;
  logic [7:0]  phase_index;

  modport source (output valid, output cycle_count, output phase_index, input ready);
  modport sink   (input valid, input cycle_count, input phase_index, output ready);
endinterface

interface lws_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        amp_code;
  logic signed [8:0] pitch_code;

  modport source (output valid, output amp_code, output pitch_code, input ready);
  modport sink   (input valid, input amp_code, input pitch_code, output ready);
endinterface

@@ design/lfo_waveform_sample_hold.sv @@
// Top level of the LFO waveform generator with noise sample-and-hold.
//
//   channel  direction  contents
//   in_ch    sink       cycle_count[15:0], phase_index[7:0]
//   out_ch   source     amp_code[7:0], pitch_code[8:0] signed
//   cfg_*    write      wave_select[1:0] on cfg_data when cfg_we is high
//
// One transaction is accepted per clock cycle while in_ch ready is high; it is captured in the input
// register, shaped, and loaded into the result register when that register is empty or being emptied,
// and is presented on out_ch from the result register, so it passes the input and result registers.
// Reset is synchronous (rst_n low); there is no clearing pass.
// When the result register is full and not taken, the input register holds and in_ch
// ready falls only if the input register is also full.
`include "lfo_waveform_sample_hold_assert.svh"

module lfo_waveform_sample_hold
  import lws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  lws_in_if.sink      in_ch,
  lws_out_if.source   out_ch
);

  // Configuration register.
  wave_t wave_r, wave_nxt;

  // Input register stage.
  logic               s1_valid_r, s1_valid_nxt;
  logic [CYCLE_W-1:0] s1_cycle_r;
  logic [PHASE_W-1:0] s1_phase_r;

  // Result register stage.
  logic                      out_valid_r, out_valid_nxt;
  logic [AMP_W-1:0]          out_amp_r;
  logic signed [PITCH_W-1:0] out_pitch_r;

  logic                      in_take;
  logic                      advance;
  hold_req_t                 hold_req;
  logic [AMP_W-1:0]          held_value;
  logic [AMP_W-1:0]          amp;
  logic signed [PITCH_W-1:0] pitch;

  // The input stage moves on whenever the result register is empty or is being emptied.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // The sample-and-hold state advances only when an item in that mode leaves the input
  // stage, so draws happen in transaction order.
  assign hold_req.take  = advance && (wave_r == WAVE_SH);
  assign hold_req.cycle = s1_cycle_r;

  lws_noise_hold u_noise_hold (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (hold_req),
    .held_value (held_value)
  );

  lws_shape u_shape (
    .wave       (wave_r),
    .phase      (s1_phase_r),
    .held_value (held_value),
    .amp        (amp),
    .pitch      (pitch)
  );

  assign wave_nxt = cfg_we ? wave_t'(cfg_data) : wave_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r      <= WAVE_SAW;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wave_r      <= wave_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cycle_r <= in_ch.cycle_count;
      s1_phase_r <= in_ch.phase_index;
    end
    if (advance) begin
      out_amp_r   <= amp;
      out_pitch_r <= pitch;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.amp_code   = out_amp_r;
  assign out_ch.pitch_code = out_pitch_r;

  // A full pipeline with a stalled output must refuse new transactions.
  `LWS_ASSERT_SAME(a_full_refuses, s1_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready)
  // An item that leaves the input stage is waiting in the result register next cycle.
  `LWS_ASSERT_NEXT(a_advance_lands, advance, out_valid_r)
  // A held input item stays in the input stage while it cannot move on.
  `LWS_ASSERT_NEXT(a_stage_holds, s1_valid_r && !advance, s1_valid_r && $stable(s1_phase_r))
  // The square wave only ever produces the two extreme amplitude codes.
  `LWS_ASSERT_SAME(a_square_amp, advance && wave_r == WAVE_SQUARE,
                   amp == 8'd0 || amp == 8'd255)

endmodule

@@ design/lws_noise_hold.sv @@
// Sample-and-hold state with the noise register and its eight-bit draw.
module lws_noise_hold
  import lws_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  hold_req_t        req,
  output logic [AMP_W-1:0] held_value
);

  logic [15:0]        shift_r, shift_nxt;
  logic               prior_r, prior_nxt;
  logic [CYCLE_W-1:0] last_r, last_nxt;
  logic               seen_r, seen_nxt;
  logic [AMP_W-1:0]   held_r, held_nxt;

  noise_t           st;
  logic [AMP_W-1:0] drawn;
  logic             need_draw;

  // Eight noise steps, first bit out lands in the MSB.
  always_comb begin
    st    = '{shift: shift_r, prior: prior_r};
    drawn = '0;
    for (int k = 0; k < DRAW_BITS; k++) begin
      drawn = {drawn[AMP_W-2:0], st.shift[0]};
      st    = noise_step(st);
    end
  end

  assign need_draw  = !seen_r || (req.cycle != last_r);
  assign held_value = need_draw ? drawn : held_r;

  always_comb begin
    shift_nxt = shift_r;
    prior_nxt = prior_r;
    last_nxt  = last_r;
    seen_nxt  = seen_r;
    held_nxt  = held_r;
    if (req.take && need_draw) begin
      shift_nxt = st.shift;
      prior_nxt = st.prior;
      last_nxt  = req.cycle;
      seen_nxt  = 1'b1;
      held_nxt  = drawn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      prior_r <= 1'b0;
      last_r  <= '0;
      seen_r  <= 1'b0;
      held_r  <= HELD_RESET;
    end else begin
      shift_r <= shift_nxt;
      prior_r <= prior_nxt;
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

@@ design/lws_shape.sv @@
// Waveform shaping: amplitude and pitch codes for each selectable wave.
module lws_shape
  import lws_pkg::*;
(
  input  wave_t                     wave,
  input  logic [PHASE_W-1:0]        phase,
  input  logic [AMP_W-1:0]          held_value,
  output logic [AMP_W-1:0]          amp,
  output logic signed [PITCH_W-1:0] pitch
);

  logic [PITCH_W-1:0] ph9;
  logic [PITCH_W-1:0] dbl;

  assign ph9 = {1'b0, phase};
  assign dbl = {phase, 1'b0};

  always_comb begin
    unique case (wave)
      WAVE_SAW: begin
        amp   = ~phase;
        pitch = phase[7] ? (ph9 - 9'd255) : ph9;
      end
      WAVE_SQUARE: begin
        amp   = phase[7] ? 8'd0 : 8'd255;
        pitch = phase[7] ? -9'sd128 : 9'sd128;
      end
      WAVE_TRI: begin
        amp = phase[7] ? {phase[6:0], 1'b0} : ~{phase[6:0], 1'b0};
        unique case (phase[7:6])
          2'b00:   pitch = dbl;
          2'b01:   pitch = 9'd255 - dbl;
          2'b10:   pitch = 9'd256 - dbl;
          default: pitch = dbl - 9'd511;
        endcase
      end
      default: begin
        amp   = held_value;
        pitch = {1'b0, held_value} - 9'd128 + {8'd0, held_value[7]};
      end
    endcase
  end

endmodule

@@ tb/sv/lfo_waveform_sample_hold_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the LFO waveform generator with noise sample-and-hold.
module lfo_waveform_sample_hold_tb;
  import lws_pkg::*;

  localparam int HALF_PERIOD      = 5;
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_ITEMS     = 800;
  localparam int LONG_HOLD_AT     = 200;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT       = 2000;
  localparam int SETTLE_CYCLES    = 4;
  localparam int MAX_REPORTS      = 200;

  // One set of result codes, as the block should produce them.
  typedef struct packed {
    logic [7:0] amp;
    logic [8:0] pitch;
  } lfo_shape_t;

  // The scoreboard keeps its own copy of the wave selection and of the
  // sample-and-hold state, and works out the codes for every accepted input.
  class lfo_scoreboard;
    wave_t       wave;
    logic [15:0] lfsr;
    logic        lfsr_prior;
    logic [15:0] last_cycle;
    bit          cycle_seen;
    logic [7:0]  held;
    lfo_shape_t  expected_q[$];
    int          errors;

    function void reset_state();
      wave       = WAVE_SAW;
      lfsr       = 16'h0000;
      lfsr_prior = 1'b0;
      last_cycle = 16'h0000;
      cycle_seen = 1'b0;
      held       = 8'd128;
      expected_q.delete();
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // One shift of the noise register. An all-zero register with a zero
    // previous bit would lock up, so a one is forced into the top instead.
    function logic noise_bit();
      logic out_bit;
      logic top;
      out_bit = lfsr[0];
      if (lfsr == 16'h0000 && !lfsr_prior) begin
        top = 1'b1;
      end else begin
        top = lfsr[2] ^ lfsr_prior;
      end
      lfsr_prior = out_bit;
      lfsr = {top, lfsr[15:1]};
      return out_bit;
    endfunction

    // Eight noise bits, first one ending up as the most significant.
    function logic [7:0] draw_held();
      logic [7:0] v;
      v = 8'd0;
      for (int k = 0; k < 8; k++) begin
        v = {v[6:0], noise_bit()};
      end
      return v;
    endfunction

    function void note_input(logic [15:0] cyc, logic [7:0] idx);
      int         i;
      int         amp;
      int         pitch;
      lfo_shape_t shape;
      i = idx;
      case (wave)
        WAVE_SAW: begin
          amp   = 255 - i;
          pitch = (i < 128) ? i : i - 255;
        end
        WAVE_SQUARE: begin
          amp   = (i < 128) ? 255 : 0;
          pitch = (i < 128) ? 128 : -128;
        end
        WAVE_TRI: begin
          amp = (i < 128) ? 255 - 2 * i : 2 * i - 256;
          if (i < 64) begin
            pitch = 2 * i;
          end else if (i < 128) begin
            pitch = 255 - 2 * i;
          end else if (i < 192) begin
            pitch = 256 - 2 * i;
          end else begin
            pitch = 2 * i - 511;
          end
        end
        default: begin
          if (!cycle_seen || cyc != last_cycle) begin
            held       = draw_held();
            last_cycle = cyc;
            cycle_seen = 1'b1;
          end
          amp   = held;
          pitch = int'(held) - 128 + ((held >= 8'd128) ? 1 : 0);
        end
      endcase
      shape.amp   = amp[7:0];
      shape.pitch = pitch[8:0];
      expected_q.push_back(shape);
    endfunction

    function void check_result(logic [7:0] amp, logic [8:0] pitch);
      lfo_shape_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result, expected none, actual amp %0d pitch %0d",
                   $time, amp, $signed(pitch));
        end
        return;
      end
      want = expected_q.pop_front();
      if (amp !== want.amp) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: amp_code mismatch, expected %0d, actual %0d",
                   $time, want.amp, amp);
        end
      end
      if (pitch !== want.pitch) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: pitch_code mismatch, expected %0d, actual %0d",
                   $time, $signed(want.pitch), $signed(pitch));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_data;

  lws_in_if  in_ch ();
  lws_out_if out_ch ();

  lfo_scoreboard sb;

  // Set by the stimulus to ask the receiver for one long hold-off; the
  // receiver clears it once the hold-off is over.
  bit long_hold;
  int burst_left;
  int quiet_cycles;

  lfo_waveform_sample_hold dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Both channels are observed at the rising edge, before any of that edge's
  // updates land, so every transaction is seen exactly as the block saw it.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_input(in_ch.cycle_count, in_ch.phase_index);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.amp_code, out_ch.pitch_code);
    end
  end

  // The watchdog counts cycles in which no transaction moves on either side.
  // A stall longer than any the stimulus can cause means the block is stuck.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("lfo_waveform_sample_hold_tb: errors");
      $finish;
    end
  end

  // The receiver follows a rotating 16-bit pattern of ready bits, chosen
  // afresh whenever its age runs out. About a quarter of the patterns are all
  // ones, which gives stretches with no back-pressure at all. When the
  // stimulus asks for it, ready is held low for a long stretch so that the
  // result and input registers fill and the block pushes back on its input.
  initial begin
    logic [15:0] pattern;
    int          age;
    out_ch.ready = 1'b0;
    pattern = '1;
    age = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      if (age == 0) begin
        pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom());
        age = $urandom_range(16, 96);
      end
      age--;
      out_ch.ready <= pattern[0];
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  task automatic idle(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offers one transaction and returns at the edge that accepts it. The sender
  // works in bursts: when a burst is used up it may pause before the next one
  // starts, except while the long hold-off is running, when it keeps offering
  // so that the block really fills up.
  task automatic send_item(logic [15:0] cyc, logic [7:0] idx);
    if (burst_left == 0) begin
      if (!long_hold && $urandom_range(0, 3) != 0) begin
        idle($urandom_range(1, 8));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.cycle_count <= cyc;
    in_ch.phase_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering and waits until every expected result has come back, then
  // gives the two pipeline stages time to empty before anything else happens.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle, so the predictor can switch at once.
  task automatic write_wave(wave_t w);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.wave = w;
  endtask

  initial begin
    logic [23:0] phase;
    int          random_sent;
    int          span;
    sb = new;
    sb.reset_state();
    long_hold  = 1'b0;
    burst_left = 0;
    quiet_cycles = 0;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_data = 2'd0;
    in_ch.valid       = 1'b0;
    in_ch.cycle_count = 16'd0;
    in_ch.phase_index = 8'd0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sample-and-hold straight after reset: the first transaction must draw
    // even though its count equals the reset value of the last count seen.
    // The noise register starts at zero, so this draw also goes through the
    // lock-up escape. A repeated count then holds, a new count draws again.
    write_wave(WAVE_SH);
    send_item(16'd0, 8'd0);
    send_item(16'd0, 8'd255);
    send_item(16'hffff, 8'd128);
    send_item(16'hffff, 8'd127);
    drain();

    // Triangle across every breakpoint of both shapes, with the count moving
    // on each transaction while sample-and-hold is not selected.
    write_wave(WAVE_TRI);
    send_item(16'd1, 8'd0);
    send_item(16'd2, 8'd63);
    send_item(16'd3, 8'd64);
    send_item(16'd4, 8'd127);
    send_item(16'd5, 8'd128);
    send_item(16'd6, 8'd191);
    send_item(16'd7, 8'd192);
    send_item(16'd8, 8'd255);
    drain();

    // Back in sample-and-hold, the counts seen in the other mode must not
    // count: the last count seen there still holds, a different one draws.
    write_wave(WAVE_SH);
    send_item(16'hffff, 8'd10);
    send_item(16'd8, 8'd20);
    drain();

    write_wave(WAVE_SQUARE);
    send_item(16'd9, 8'd0);
    send_item(16'd9, 8'd127);
    send_item(16'd9, 8'd128);
    send_item(16'd9, 8'd255);
    drain();

    write_wave(WAVE_SAW);
    send_item(16'd10, 8'd0);
    send_item(16'd10, 8'd127);
    send_item(16'd10, 8'd128);
    send_item(16'd10, 8'd255);
    drain();

    // Random phases, each under a randomly chosen wave. The input behaves like
    // a real phase accumulator advancing by a random step, so counts mostly
    // repeat over a waveform period and then move on to the next, which is what the
    // sample-and-hold logic sees in use. Now and then the phase jumps to a
    // random value, which covers every count bit and wrap-around.
    phase = 24'd0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      write_wave(wave_t'($urandom_range(0, 3)));
      span = $urandom_range(30, 120);
      for (int n = 0; n < span; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          phase = 24'($urandom());
        end else begin
          phase = phase + 24'($urandom_range(0, 96));
        end
        if (random_sent == LONG_HOLD_AT) begin
          long_hold = 1'b1;
        end
        send_item(phase[23:8], phase[7:0]);
        random_sent++;
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lfo_waveform_sample_hold_tb: clean");
    end else begin
      $display("lfo_waveform_sample_hold_tb: errors");
    end
    $finish;
  end

endmodule

@@ lfo_waveform_sample_hold.f @@
+incdir+design
design/lws_pkg.sv
design/lws_if.sv
design/lws_noise_hold.sv
design/lws_shape.sv
design/lfo_waveform_sample_hold.sv
tb/sv/lfo_waveform_sample_hold_tb.sv
